/* sv/pnc_pkg.sv */
package pnc_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;

  // Microprogram step address
  localparam int StepW = 5;
  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_IDLE     = 5'd0;
  localparam step_t STEP_SIZE     = 5'd1;
  localparam step_t STEP_DIV1     = 5'd2;
  localparam step_t STEP_WAIT1    = 5'd3;
  localparam step_t STEP_ROOT     = 5'd4;
  localparam step_t STEP_LOW_REM  = 5'd5;
  localparam step_t STEP_LOW_CHK  = 5'd6;
  localparam step_t STEP_LOW_ADD  = 5'd7;
  localparam step_t STEP_INC      = 5'd8;
  localparam step_t STEP_DEC      = 5'd9;
  localparam step_t STEP_LOW_END  = 5'd10;
  localparam step_t STEP_DIV2     = 5'd11;
  localparam step_t STEP_WAIT2    = 5'd12;
  localparam step_t STEP_HIGH_REM = 5'd13;
  localparam step_t STEP_HIGH_SQ  = 5'd14;
  localparam step_t STEP_HIGH_CHK = 5'd15;
  localparam step_t STEP_HIGH_ADD = 5'd16;
  localparam step_t STEP_FIN      = 5'd17;
  localparam step_t STEP_RETURN   = 5'd18;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV_START,
    ACT_ADD_D,
    ACT_INC_D,
    ACT_DEC_D,
    ACT_ADD_Q,
    ACT_WRITE_OUT
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_MAG_LT2,
    C_DIV_BUSY,
    C_Q_LT_D,
    C_Q_EQ_D,
    C_R_NZ,
    C_SUM_GT,
    C_D_LT2,
    C_OUT_BLOCKED
  } cond_e;

  // Control word: action this step, then jump to target if cond holds, else fall through
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t step);
    uword_t uw;
    unique case (step)
      STEP_IDLE:     uw = '{act: ACT_LOAD,      cond: C_NO_INPUT,    target: STEP_IDLE};
      STEP_SIZE:     uw = '{act: ACT_NONE,      cond: C_MAG_LT2,     target: STEP_FIN};
      // ascending divisors up to the square root
      STEP_DIV1:     uw = '{act: ACT_DIV_START, cond: C_NEVER,       target: STEP_IDLE};
      STEP_WAIT1:    uw = '{act: ACT_NONE,      cond: C_DIV_BUSY,    target: STEP_WAIT1};
      STEP_ROOT:     uw = '{act: ACT_NONE,      cond: C_Q_LT_D,      target: STEP_DEC};
      STEP_LOW_REM:  uw = '{act: ACT_NONE,      cond: C_R_NZ,        target: STEP_INC};
      STEP_LOW_CHK:  uw = '{act: ACT_NONE,      cond: C_SUM_GT,      target: STEP_FIN};
      STEP_LOW_ADD:  uw = '{act: ACT_ADD_D,     cond: C_NEVER,       target: STEP_IDLE};
      STEP_INC:      uw = '{act: ACT_INC_D,     cond: C_ALWAYS,      target: STEP_DIV1};
      // paired divisors, walked back down so the cofactors ascend
      STEP_DEC:      uw = '{act: ACT_DEC_D,     cond: C_NEVER,       target: STEP_IDLE};
      STEP_LOW_END:  uw = '{act: ACT_NONE,      cond: C_D_LT2,       target: STEP_FIN};
      STEP_DIV2:     uw = '{act: ACT_DIV_START, cond: C_NEVER,       target: STEP_IDLE};
      STEP_WAIT2:    uw = '{act: ACT_NONE,      cond: C_DIV_BUSY,    target: STEP_WAIT2};
      STEP_HIGH_REM: uw = '{act: ACT_NONE,      cond: C_R_NZ,        target: STEP_DEC};
      STEP_HIGH_SQ:  uw = '{act: ACT_NONE,      cond: C_Q_EQ_D,      target: STEP_DEC};
      STEP_HIGH_CHK: uw = '{act: ACT_NONE,      cond: C_SUM_GT,      target: STEP_FIN};
      STEP_HIGH_ADD: uw = '{act: ACT_ADD_Q,     cond: C_ALWAYS,      target: STEP_DEC};
      STEP_FIN:      uw = '{act: ACT_WRITE_OUT, cond: C_OUT_BLOCKED, target: STEP_FIN};
      STEP_RETURN:   uw = '{act: ACT_NONE,      cond: C_ALWAYS,      target: STEP_IDLE};
      default:       uw = '{act: ACT_NONE,      cond: C_ALWAYS,      target: STEP_IDLE};
    endcase
    return uw;
  endfunction

endpackage

/* sv/pnc_div.sv */
module pnc_div #(
  parameter int Width = pnc_pkg::NUMBER_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);
  import pnc_pkg::*;

  localparam int CntW = $clog2(Width + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] quot_q, quot_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;

  // One quotient bit a cycle, restoring; divisor must hold while busy
  always_comb begin
    shifted = {rem_q, quot_q[Width-1]};
    diff    = shifted - {1'b0, divisor_i};
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    if (start_i) begin
      cnt_d  = CntW'(Width);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_o) begin
      cnt_d  = cnt_q - CntW'(1);
      quot_d = {quot_q[Width-2:0], ~diff[Width]};
      rem_d  = diff[Width] ? shifted[Width-1:0] : diff[Width-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* sv/perfect_number_checker_unit.sv */
// Perfect number checker.
// Input channel (in_valid_i / in_ready_o) carries one signed number_i a beat.
// Output channel (out_valid_o / out_ready_i) returns one beat per input:
// is_perfect_o and divisor_sum_o, the sum of proper divisors of |number_i|
// or the partial sum at which it first passed |number_i|.
// A microcoded sequencer walks trial divisors d upwards while d*d <= |n|,
// then walks them back down to add the paired cofactors in ascending order.
// Every trial runs through a bit-serial divider, and an item runs roughly
// 2 * sqrt(|n|) trials, fewer when the sum overshoots early. For |n| below
// 2 no trial runs: the sequencer goes straight to writing the result.
// One item is worked at a time: in_ready_o is high only while the sequencer
// idles. A finished result sits in the output register; the next item is
// accepted while it waits, and if the receiver still stalls when that item
// finishes, the sequencer holds until the register frees.
// Reset empties the output register and idles the sequencer.
module perfect_number_checker_unit #(
  parameter int NUMBER_WIDTH = pnc_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [NUMBER_WIDTH-1:0] number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_perfect_o,
  output logic        [NUMBER_WIDTH-1:0] divisor_sum_o
);
  import pnc_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;
  logic   take;

  logic [NUMBER_WIDTH-1:0] mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [NUMBER_WIDTH-1:0] d_q, d_d;
  logic [NUMBER_WIDTH-1:0] sum_q, sum_d;
  logic [NUMBER_WIDTH-1:0] raw;

  logic                    out_valid_q, out_valid_d;
  logic                    perfect_q, perfect_d;
  logic [NUMBER_WIDTH-1:0] res_sum_q, res_sum_d;
  logic                    out_free;
  logic                    out_load;

  logic                    div_start;
  logic                    div_busy;
  logic [NUMBER_WIDTH-1:0] quot;
  logic [NUMBER_WIDTH-1:0] rem;

  pnc_div #(
    .Width(NUMBER_WIDTH)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(mag_q),
    .divisor_i (d_q),
    .busy_o    (div_busy),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign uw         = ucode(step_q);
  assign raw        = $unsigned(number_i);
  assign in_ready_o = (step_q == STEP_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign div_start  = (uw.act == ACT_DIV_START);
  assign out_load   = (uw.act == ACT_WRITE_OUT) && out_free;

  // Branch condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !in_valid_i;
      C_MAG_LT2:     take = (mag_q[NUMBER_WIDTH-1:1] == '0);
      C_DIV_BUSY:    take = div_busy;
      C_Q_LT_D:      take = (quot < d_q);
      C_Q_EQ_D:      take = (quot == d_q);
      C_R_NZ:        take = (rem != '0);
      C_SUM_GT:      take = (sum_q > mag_q);
      C_D_LT2:       take = (d_q[NUMBER_WIDTH-1:1] == '0);
      C_OUT_BLOCKED: take = !out_free;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    step_d = take ? uw.target : step_q + step_t'(1);
  end

  // Datapath actions
  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    d_d   = d_q;
    sum_d = sum_q;
    unique case (uw.act)
      ACT_LOAD: begin
        if (in_valid_i) begin
          neg_d = raw[NUMBER_WIDTH-1];
          mag_d = raw[NUMBER_WIDTH-1] ? -raw : raw;
          d_d   = NUMBER_WIDTH'(1);
          sum_d = '0;
        end
      end
      ACT_ADD_D: sum_d = sum_q + d_q;
      ACT_INC_D: d_d   = d_q + NUMBER_WIDTH'(1);
      ACT_DEC_D: d_d   = d_q - NUMBER_WIDTH'(1);
      ACT_ADD_Q: sum_d = sum_q + quot;
      default: ;
    endcase
  end

  // Output register: load when free, drop on the consumed beat
  always_comb begin
    out_valid_d = out_valid_q;
    perfect_d   = perfect_q;
    res_sum_d   = res_sum_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      perfect_d   = !neg_q && (mag_q != '0) && (sum_q == mag_q);
      res_sum_d   = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    d_q       <= d_d;
    sum_q     <= sum_d;
    perfect_q <= perfect_d;
    res_sum_q <= res_sum_d;
  end

  assign out_valid_o   = out_valid_q;
  assign is_perfect_o  = perfect_q;
  assign divisor_sum_o = res_sum_q;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> step_q == STEP_SIZE)
    else $error("accepted beat did not start the program");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (step_q == STEP_WAIT1 || step_q == STEP_WAIT2))
    else $error("divider running outside a wait step");

  a_pair_trial_above_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_DIV2 |-> d_q[NUMBER_WIDTH-1:1] != '0)
    else $error("paired trial with divisor below two");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && step_q == STEP_RETURN)
    else $error("finished item did not reach the output register");
`endif

endmodule
